// ===== rtl/dsbe_pkg.sv =====
// Shared constants and types for the delayed smoothing background estimator.
package dsbe_pkg;

  localparam int MAX_WINDOW    = 1024;
  localparam int ADDR_BITS     = $clog2(MAX_WINDOW);
  localparam int COUNT_BITS    = 16;
  localparam int WIN_BITS      = 11;
  localparam int ALPHA_BITS    = 17;
  localparam int SLEEP_BITS    = 16;
  localparam int CNT_BITS      = 17;
  localparam int SUM_BITS      = 26;
  localparam int EST_BITS      = 32;
  localparam int FRAC_BITS     = 16;
  localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
  localparam int DIV_STEPS     = DIVIDEND_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);
  localparam int PROD_A_BITS   = ALPHA_BITS + COUNT_BITS;
  localparam int PROD_B_BITS   = ALPHA_BITS + EST_BITS;
  localparam int SMOOTH_BITS   = EST_BITS + 2;

  localparam logic [ALPHA_BITS-1:0] ONE_Q16     = ALPHA_BITS'(65536);
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(6554);
  localparam logic [WIN_BITS-1:0]   WIN_RESET   = WIN_BITS'(16);
  localparam logic [SLEEP_BITS-1:0] SLEEP_RESET = '0;

  // operating modes, also reported as the phase of each result
  localparam logic [1:0] MODE_COLLECT = 2'd0;
  localparam logic [1:0] MODE_UPDATE  = 2'd1;
  localparam logic [1:0] MODE_TEST    = 2'd2;

  // register map (word index)
  localparam int CFG_ADDR_BITS = 4;
  localparam logic [1:0] REG_ALPHA  = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_SLEEP  = 2'd2;

  typedef struct packed {
    logic load_in;
    logic access;
    logic mul;
    logic add;
    logic div_start;
    logic div_take;
    logic out_load;
  } dsbe_cmd_t;

  typedef struct packed {
    logic collect;
    logic collect_end;
    logic div_done;
    logic out_free;
  } dsbe_status_t;

endpackage

// ===== rtl/dsbe_ctrl.sv =====
// Sequencing state machine: one request at a time through access, smoothing or divide.
module dsbe_ctrl import dsbe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  dsbe_status_t status,
  output logic         in_tready,
  output dsbe_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ACCESS   = 3'd1;
  localparam logic [2:0] S_MUL      = 3'd2;
  localparam logic [2:0] S_ADD      = 3'd3;
  localparam logic [2:0] S_DIV_GO   = 3'd4;
  localparam logic [2:0] S_DIV_WAIT = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_ACCESS;
        end
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        if (status.collect) begin
          state_nxt = status.collect_end ? S_DIV_GO : S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/dsbe_div.sv =====
// Restoring divider, one quotient bit per cycle, for the initial background.
module dsbe_div import dsbe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [WIN_BITS-1:0]      divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  logic                     busy_r;
  logic                     done_r;
  logic [DIV_CNT_BITS-1:0]  cnt_r;
  logic [WIN_BITS-1:0]      rem_r;
  logic [WIN_BITS-1:0]      div_r;
  logic [DIVIDEND_BITS-1:0] quo_r;
  logic [WIN_BITS:0]        trial;
  logic                     fits;

  // remainder stays below the divisor, so it fits in WIN_BITS
  assign trial = {rem_r, quo_r[DIVIDEND_BITS-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_BITS'(1);
        if (cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? WIN_BITS'(trial - {1'b0, div_r}) : trial[WIN_BITS-1:0];
      quo_r <= {quo_r[DIVIDEND_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/dsbe_datapath.sv =====
// Delay memory, running sum, smoothing multipliers, divider and output register.
module dsbe_datapath import dsbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dsbe_cmd_t             cmd,
  output dsbe_status_t          status,
  input  logic [COUNT_BITS-1:0] in_count,
  input  logic [ALPHA_BITS-1:0] alpha,
  input  logic [WIN_BITS-1:0]   window,
  input  logic [SLEEP_BITS-1:0] sleep,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [EST_BITS-1:0]   out_background,
  output logic [1:0]            out_phase,
  output logic                  out_test_now
);

  logic [COUNT_BITS-1:0] mem [MAX_WINDOW];

  logic [COUNT_BITS-1:0]  count_r;
  logic [COUNT_BITS-1:0]  rd_r;
  logic [1:0]             ran_r;
  logic [PROD_A_BITS-1:0] prod_a_r;
  logic [PROD_B_BITS-1:0] prod_b_r;
  logic [EST_BITS-1:0]    out_bg_r;
  logic [1:0]             out_phase_r;
  logic                   out_test_r;

  logic [ADDR_BITS-1:0]   ptr_r,   ptr_nxt;
  logic [CNT_BITS-1:0]    cnt_r,   cnt_nxt;
  logic [SUM_BITS-1:0]    sum_r,   sum_nxt;
  logic [EST_BITS-1:0]    est_r,   est_nxt;
  logic [1:0]             mode_r,  mode_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [WIN_BITS-1:0]      w_eff;
  logic [ALPHA_BITS-1:0]    alpha_eff;
  logic [ADDR_BITS-1:0]     p_eff;
  logic [WIN_BITS-1:0]      ptr_inc;
  logic [CNT_BITS-1:0]      cnt_inc;
  logic [CNT_BITS-1:0]      cnt_dec;
  logic                     collect_end;
  logic [SMOOTH_BITS-1:0]   smooth_sum;
  logic                     div_done;
  logic [DIVIDEND_BITS-1:0] div_q;

  // window clamped to 1..MAX_WINDOW, alpha clamped to one
  always_comb begin
    if (window == '0) begin
      w_eff = WIN_BITS'(1);
    end else if (window > WIN_BITS'(MAX_WINDOW)) begin
      w_eff = WIN_BITS'(MAX_WINDOW);
    end else begin
      w_eff = window;
    end
    alpha_eff = (alpha > ONE_Q16) ? ONE_Q16 : alpha;
  end

  assign p_eff       = ({1'b0, ptr_r} >= w_eff) ? '0 : ptr_r;
  assign ptr_inc     = {1'b0, p_eff} + WIN_BITS'(1);
  assign cnt_inc     = cnt_r + CNT_BITS'(1);
  assign cnt_dec     = (cnt_r != '0) ? cnt_r - CNT_BITS'(1) : cnt_r;
  assign collect_end = cnt_inc >= CNT_BITS'(w_eff);
  assign smooth_sum  = SMOOTH_BITS'(prod_a_r)
                     + SMOOTH_BITS'(prod_b_r[PROD_B_BITS-1:FRAC_BITS]);

  dsbe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({sum_r, {FRAC_BITS{1'b0}}}),
    .divisor  (w_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    ptr_nxt  = ptr_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    est_nxt  = est_r;
    mode_nxt = mode_r;
    if (cmd.access) begin
      ptr_nxt = (ptr_inc >= w_eff) ? '0 : ptr_inc[ADDR_BITS-1:0];
      case (mode_r)
        MODE_COLLECT: begin
          sum_nxt = sum_r + SUM_BITS'(count_r);
          cnt_nxt = cnt_inc;
          if (collect_end) begin
            ptr_nxt = '0;
            if (sleep != '0) begin
              cnt_nxt  = CNT_BITS'(sleep);
              mode_nxt = MODE_UPDATE;
            end else begin
              cnt_nxt  = '0;
              mode_nxt = MODE_TEST;
            end
          end
        end
        MODE_UPDATE: begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            mode_nxt = MODE_TEST;
          end
        end
        default: mode_nxt = MODE_TEST;
      endcase
    end
    if (cmd.div_start) begin
      sum_nxt = '0;
    end
    if (cmd.add) begin
      est_nxt = (smooth_sum[SMOOTH_BITS-1:EST_BITS] != '0) ? '1
                                                            : smooth_sum[EST_BITS-1:0];
    end
    if (cmd.div_take) begin
      est_nxt = (div_q[DIVIDEND_BITS-1:EST_BITS] != '0) ? '1 : div_q[EST_BITS-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      est_r       <= '0;
      mode_r      <= MODE_COLLECT;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      est_r       <= est_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // read-first: the oldest count comes out while the new one goes in
  always_ff @(posedge clk) begin
    if (cmd.access) begin
      rd_r       <= mem[p_eff];
      mem[p_eff] <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      count_r <= in_count;
    end
    if (cmd.access) begin
      ran_r <= (mode_r == MODE_COLLECT || mode_r == MODE_UPDATE) ? mode_r : MODE_TEST;
    end
    if (cmd.mul) begin
      prod_a_r <= PROD_A_BITS'(alpha_eff) * PROD_A_BITS'(rd_r);
      prod_b_r <= PROD_B_BITS'(ONE_Q16 - alpha_eff) * PROD_B_BITS'(est_r);
    end
    if (cmd.out_load) begin
      out_bg_r    <= est_r;
      out_phase_r <= ran_r;
      out_test_r  <= (ran_r == MODE_TEST);
    end
  end

  assign status.collect     = (mode_r == MODE_COLLECT);
  assign status.collect_end = collect_end;
  assign status.div_done    = div_done;
  assign status.out_free    = !out_valid_r || out_tready;

  assign out_tvalid     = out_valid_r;
  assign out_background = out_bg_r;
  assign out_phase      = out_phase_r;
  assign out_test_now   = out_test_r;

endmodule

// ===== rtl/delayed_smoothing_background_estimator_top.sv =====
// Top level: stream ports, APB register file, controller and datapath.
// From acceptance to result valid, a request passes the states access, multiply, add and
// done in update/test mode, access and done in collect, and on the bin that ends collection
// access, divide start, a 42-step serial divide by the window, and done.
// A new request is taken only after the last result is loaded, which waits for a free output.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n, synchronous, active low) clears control state, mode, sum, estimate and the
// configuration registers; the delay memory and the data pipeline registers are not cleared.
module delayed_smoothing_background_estimator_top import dsbe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [15:0]              in_tdata,   // [15:0] count
  // result stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [31:0]              out_tdata,  // [31:0] background (Q16.16)
  output logic [2:0]               out_tuser,  // [1:0] phase, [2] test_now
  // configuration
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  logic [ALPHA_BITS-1:0] alpha_r;
  logic [WIN_BITS-1:0]   window_r;
  logic [SLEEP_BITS-1:0] sleep_r;
  logic                  cfg_wr;
  logic [1:0]            cfg_idx;

  dsbe_cmd_t    cmd;
  dsbe_status_t status;

  logic [EST_BITS-1:0] out_background;
  logic [1:0]          out_phase;
  logic                out_test_now;

  // ---- APB register file: zero wait states, written in the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= ALPHA_RESET;
      window_r <= WIN_RESET;
      sleep_r  <= SLEEP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ALPHA:  alpha_r  <= cfg_pwdata[ALPHA_BITS-1:0];
        REG_WINDOW: window_r <= cfg_pwdata[WIN_BITS-1:0];
        REG_SLEEP:  sleep_r  <= cfg_pwdata[SLEEP_BITS-1:0];
        default: ;  // unmapped word, ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ALPHA:  cfg_prdata = 32'(alpha_r);
      REG_WINDOW: cfg_prdata = 32'(window_r);
      REG_SLEEP:  cfg_prdata = 32'(sleep_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // ---- controller: sequences one request through the datapath
  dsbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .status    (status),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // ---- datapath: delay memory, sum, smoothing, divider, output register
  dsbe_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_count       (in_tdata),
    .alpha          (alpha_r),
    .window         (window_r),
    .sleep          (sleep_r),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_background (out_background),
    .out_phase      (out_phase),
    .out_test_now   (out_test_now)
  );

  assign out_tdata = out_background;
  assign out_tuser = {out_test_now, out_phase};

  // ---- assertions
  // one request in flight: the controller leaves idle right after taking one
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

  // test flag tracks the reported phase
  a_test_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[2] == (out_tuser[1:0] == MODE_TEST)))
    else $error("test_now disagrees with phase");

  // collection never restarts once the initial background is set
  a_no_recollect: assert property (@(posedge clk) disable iff (!rst_n)
    !status.collect |=> !status.collect)
    else $error("returned to collect mode");

  // a new result is only loaded when the output register is free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result overwritten before being taken");

endmodule
